>>> rtl/c2s_pkg.sv
// Shared constants, types and arctangent table for the Cartesian to spherical converter.
package c2s_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int SQRT_CELLS        = 32;

  // atan(2^-i), 2^32 = full turn
  localparam logic [31:0] ATAN_TABLE [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [31:0]        acc;
  } cordic_t;

endpackage

>>> rtl/cartesian_to_spherical.sv
// Top level: pipelined Cartesian to spherical conversion, y axis up.
// Takes one vector per clock, every clock; busy is always low. Each request
// gives one result, marked by out_valid, after it has passed through the
// input register, squares, sums, a 32-cell square root chain (radius and
// horizontal length side by side), a setup stage, one CORDIC cell per stage for
// azimuth and elevation side by side, and the output register. The receiver
// cannot stall; results must be taken in the cycle they appear.
module cartesian_to_spherical
  import c2s_pkg::*;
#(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  input  logic signed [COORD_WIDTH-1:0] in_z_coord,
  output logic                          out_valid,
  output logic        [COORD_WIDTH-1:0] out_radius,
  output logic signed [COORD_WIDTH-1:0] out_azimuth,
  output logic signed [COORD_WIDTH-1:0] out_elevation,
  output logic                          out_zero_vector
);

  localparam int W     = COORD_WIDTH;
  localparam int N     = CORDIC_STAGES;
  localparam int SCL   = 60 - W;
  localparam int SH    = 32 - W;
  localparam logic signed [32:0] RND = (SH > 0) ? (33'sd1 <<< ((SH > 0) ? SH - 1 : 0))
                                                : 33'sd0;
  localparam logic signed [32:0] LIM = 33'sd1 <<< (W - 2);

  assign busy = 1'b0;

  // input, squares, sums
  logic signed [W-1:0] x0_r, y0_r, z0_r;
  logic                v0_r, v1_r, v2_r;
  logic signed [W-1:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic [2*W-1:0]      xx_r, yy_r, zz_r, sxz_r, sum_r;
  logic signed [2*W-1:0] xx_nxt, yy_nxt, zz_nxt;

  assign xx_nxt = x0_r * x0_r;
  assign yy_nxt = y0_r * y0_r;
  assign zz_nxt = z0_r * z0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= start;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    x0_r  <= in_x_coord;
    y0_r  <= in_y_coord;
    z0_r  <= in_z_coord;
    xx_r  <= xx_nxt;
    yy_r  <= yy_nxt;
    zz_r  <= zz_nxt;
    x1_r  <= x0_r;
    y1_r  <= y0_r;
    z1_r  <= z0_r;
    sxz_r <= xx_r + zz_r;
    sum_r <= xx_r + zz_r + yy_r;
    x2_r  <= x1_r;
    y2_r  <= y1_r;
    z2_r  <= z1_r;
  end

  // square root chains
  sqrt_t rs [0:SQRT_CELLS];
  sqrt_t hs [0:SQRT_CELLS];

  assign rs[0] = '{rad: 64'(sum_r), rem: '0, root: '0};
  assign hs[0] = '{rad: {sxz_r, {(64-2*W){1'b0}}}, rem: '0, root: '0};

  genvar k;
  generate
    for (k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
      c2s_sqrt_cell u_r (.clk(clk), .d_i(rs[k]), .d_o(rs[k+1]));
      c2s_sqrt_cell u_h (.clk(clk), .d_i(hs[k]), .d_o(hs[k+1]));
    end
  endgenerate

  logic signed [W-1:0]   xs_r [0:SQRT_CELLS-1];
  logic signed [W-1:0]   ys_r [0:SQRT_CELLS-1];
  logic signed [W-1:0]   zs_r [0:SQRT_CELLS-1];
  logic                  zf_r [0:SQRT_CELLS-1];
  logic                  af_r [0:SQRT_CELLS-1];
  logic [SQRT_CELLS-1:0] vs_r;

  always_ff @(posedge clk) begin
    xs_r[0] <= x2_r;
    ys_r[0] <= y2_r;
    zs_r[0] <= z2_r;
    zf_r[0] <= (sum_r == '0);
    af_r[0] <= (sxz_r == '0);
    for (int i = 1; i < SQRT_CELLS; i++) begin
      xs_r[i] <= xs_r[i-1];
      ys_r[i] <= ys_r[i-1];
      zs_r[i] <= zs_r[i-1];
      zf_r[i] <= zf_r[i-1];
      af_r[i] <= af_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= '0;
    end else begin
      vs_r <= {vs_r[SQRT_CELLS-2:0], v2_r};
    end
  end

  // setup: round radius, load CORDIC lanes
  localparam int LS = SQRT_CELLS - 1;
  cordic_t            az_nxt, el_nxt;
  logic signed [63:0] xe, ye, ze;
  logic [31:0]        rr;
  logic [W-1:0]       rad_nxt;

  always_comb begin
    xe = 64'(xs_r[LS]) <<< SCL;
    ye = 64'(ys_r[LS]) <<< SCL;
    ze = 64'(zs_r[LS]) <<< SCL;
    rr = rs[SQRT_CELLS].root + 32'((rs[SQRT_CELLS].rem > {2'b00, rs[SQRT_CELLS].root}));
    rad_nxt = rr[W-1:0];
    if (xe[63]) begin
      az_nxt = '{a: -xe, b: -ze, acc: 32'h80000000};
    end else begin
      az_nxt = '{a: xe, b: ze, acc: 32'h0};
    end
    el_nxt = '{a: {4'b0000, hs[SQRT_CELLS].root, 28'd0}, b: ye, acc: 32'h0};
  end

  cordic_t az_c [0:N];
  cordic_t el_c [0:N];
  logic [W-1:0] rd_r [0:N];
  logic         zc_r [0:N];
  logic         ac_r [0:N];
  logic [N:0]   vc_r;

  always_ff @(posedge clk) begin
    az_c[0] <= az_nxt;
    el_c[0] <= el_nxt;
    rd_r[0] <= rad_nxt;
    zc_r[0] <= zf_r[LS];
    ac_r[0] <= af_r[LS];
    for (int i = 1; i <= N; i++) begin
      rd_r[i] <= rd_r[i-1];
      zc_r[i] <= zc_r[i-1];
      ac_r[i] <= ac_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= '0;
    end else begin
      vc_r <= {vc_r[N-1:0], vs_r[LS]};
    end
  end

  generate
    for (k = 0; k < N; k++) begin : g_cordic
      c2s_cordic_cell #(.IDX(k)) u_az (.clk(clk), .c_i(az_c[k]), .c_o(az_c[k+1]));
      c2s_cordic_cell #(.IDX(k)) u_el (.clk(clk), .c_i(el_c[k]), .c_o(el_c[k+1]));
    end
  endgenerate

  // output rounding and saturation
  logic signed [32:0]   az_t, el_t, el_q;
  logic                 val_r, zero_r;
  logic [W-1:0]         rad_r;
  logic signed [W-1:0]  az_r, el_r;

  always_comb begin
    az_t = ($signed({az_c[N].acc[31], az_c[N].acc}) + RND) >>> SH;
    el_t = ($signed({el_c[N].acc[31], el_c[N].acc}) + RND) >>> SH;
    if (el_t > LIM) begin
      el_q = LIM;
    end else if (el_t < -LIM) begin
      el_q = -LIM;
    end else begin
      el_q = el_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
    end else begin
      val_r <= vc_r[N];
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= zc_r[N];
    rad_r  <= zc_r[N] ? '0 : rd_r[N];
    az_r   <= (zc_r[N] || ac_r[N]) ? '0 : az_t[W-1:0];
    el_r   <= zc_r[N] ? '0 : el_q[W-1:0];
  end

  assign out_valid       = val_r;
  assign out_zero_vector = zero_r;
  assign out_radius      = rad_r;
  assign out_azimuth     = az_r;
  assign out_elevation   = el_r;

  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_vector |->
      out_radius == '0 && out_azimuth == '0 && out_elevation == '0)
    else $error("zero vector result not cleared");

  a_el_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 33'(out_elevation) <= LIM && 33'(out_elevation) >= -LIM)
    else $error("elevation out of range");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r[N] |=> out_valid)
    else $error("lost request at output");

endmodule

>>> rtl/c2s_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
module c2s_sqrt_cell
  import c2s_pkg::*;
(
  input  logic  clk,
  input  sqrt_t d_i,
  output sqrt_t d_o
);

  sqrt_t       d_r;
  sqrt_t       d_nxt;
  logic [33:0] rem_s;
  logic [33:0] trial;
  logic        ge;

  always_comb begin
    rem_s       = {d_i.rem[31:0], d_i.rad[63:62]};
    trial       = {d_i.root, 2'b01};
    ge          = (rem_s >= trial);
    d_nxt.rad   = {d_i.rad[61:0], 2'b00};
    d_nxt.rem   = ge ? (rem_s - trial) : rem_s;
    d_nxt.root  = {d_i.root[30:0], ge};
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule

>>> rtl/c2s_cordic_cell.sv
// One micro-rotation cell of the vectoring CORDIC.
module c2s_cordic_cell
  import c2s_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic    clk,
  input  cordic_t c_i,
  output cordic_t c_o
);

  cordic_t            c_r;
  cordic_t            c_nxt;
  logic signed [63:0] da;
  logic signed [63:0] db;

  always_comb begin
    da = c_i.b >>> IDX;
    db = c_i.a >>> IDX;
    if (!c_i.b[63]) begin
      c_nxt.a   = c_i.a + da;
      c_nxt.b   = c_i.b - db;
      c_nxt.acc = c_i.acc + ATAN_TABLE[IDX];
    end else begin
      c_nxt.a   = c_i.a - da;
      c_nxt.b   = c_i.b + db;
      c_nxt.acc = c_i.acc - ATAN_TABLE[IDX];
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
  end

  assign c_o = c_r;

endmodule
